### hdl/xbr_pkg.sv
// Shared types, protocol codes and field widths for the XMODEM block receiver.
// No dependencies; every other file in hdl imports this package.
package xbr_pkg;

  localparam logic [7:0] C_SOH    = 8'h01;
  localparam logic [7:0] C_STX    = 8'h02;
  localparam logic [7:0] C_EOT    = 8'h04;
  localparam logic [7:0] C_ACK    = 8'h06;
  localparam logic [7:0] C_NAK    = 8'h15;
  localparam logic [7:0] C_ASKCRC = 8'h43;
  localparam logic [7:0] C_CAN    = 8'h18;
  localparam logic [7:0] C_BS     = 8'h08;

  localparam logic [15:0] CRC_POLY   = 16'h1021;
  localparam logic [10:0] SHORT_LEN  = 11'd128;
  localparam logic [10:0] LONG_LEN   = 11'd1024;
  localparam logic [7:0]  CMP_OK     = 8'hFF;
  localparam logic [15:0] SIL_MAX    = 16'hFFFF;

  localparam int unsigned ABORT_CANS  = 5;
  localparam int unsigned ABORT_BEATS = 10;

  localparam logic [15:0] LONG_TO_RST  = 16'd10000;
  localparam logic [15:0] SHORT_TO_RST = 16'd1000;
  localparam logic [3:0]  MAX_ERR_RST  = 4'd10;

  localparam logic [1:0] CFG_LONG_TO  = 2'd0;
  localparam logic [1:0] CFG_SHORT_TO = 2'd1;
  localparam logic [1:0] CFG_MAX_ERR  = 2'd2;

  localparam logic [1:0] FUNC_BYTE  = 2'd0;
  localparam logic [1:0] FUNC_TICK  = 2'd1;
  localparam logic [1:0] FUNC_START = 2'd2;

  localparam logic [1:0] VERD_NONE    = 2'd0;
  localparam logic [1:0] VERD_COMMIT  = 2'd1;
  localparam logic [1:0] VERD_DISCARD = 2'd2;

  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_TIMEOUT  = 3'd1;
  localparam logic [2:0] ERR_HEADER   = 3'd2;
  localparam logic [2:0] ERR_CMP      = 3'd3;
  localparam logic [2:0] ERR_BLOCKNUM = 3'd4;
  localparam logic [2:0] ERR_CHECK    = 3'd5;

  localparam logic [1:0] ST_IDLE     = 2'd0;
  localparam logic [1:0] ST_RECEIVE  = 2'd1;
  localparam logic [1:0] ST_FINISHED = 2'd2;
  localparam logic [1:0] ST_ABORTED  = 2'd3;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_HEADER = 3'd1,
    PH_NUM    = 3'd2,
    PH_CMP    = 3'd3,
    PH_BODY   = 3'd4,
    PH_DONE   = 3'd5,
    PH_ABORT  = 3'd6
  } phase_t;

  typedef enum logic [1:0] {
    RES_NONE  = 2'd0,
    RES_ONE   = 2'd1,
    RES_ABORT = 2'd2
  } res_kind_t;

  typedef struct packed {
    logic [15:0] long_to;
    logic [15:0] short_to;
    logic [3:0]  max_err;
  } xbr_cfg_t;

  typedef struct packed {
    phase_t      phase;
    logic [10:0] byte_index;
    logic        long_frame;
    logic [7:0]  expected_block;
    logic [7:0]  received_block;
    logic [15:0] crc;
    logic [7:0]  sum;
    logic [7:0]  check_hi;
    logic        crc_mode;
    logic [3:0]  err_cnt;
    logic [15:0] silence;
    logic        byte_seen;
    logic [31:0] committed;
  } xbr_state_t;

  typedef struct packed {
    res_kind_t   kind;
    logic        reply_valid;
    logic [7:0]  reply_byte;
    logic        data_valid;
    logic [7:0]  data_byte;
    logic [1:0]  verdict;
    logic [2:0]  err;
    logic [1:0]  status;
    logic        crc_in_use;
    logic [31:0] total;
  } xbr_res_t;

  localparam xbr_cfg_t CFG_RST = '{
    long_to:  LONG_TO_RST,
    short_to: SHORT_TO_RST,
    max_err:  MAX_ERR_RST
  };

  localparam xbr_state_t STATE_RST = '{
    phase:          PH_IDLE,
    byte_index:     11'd0,
    long_frame:     1'b0,
    expected_block: 8'd1,
    received_block: 8'd0,
    crc:            16'd0,
    sum:            8'd0,
    check_hi:       8'd0,
    crc_mode:       1'b1,
    err_cnt:        4'd0,
    silence:        16'd0,
    byte_seen:      1'b0,
    committed:      32'd0
  };

endpackage

### hdl/xbr_step.sv
// Next-state and result logic for one receiver item (line byte, tick or start).
// Purely combinational; depends on xbr_pkg.
module xbr_step import xbr_pkg::*; (
  input  xbr_state_t state_i,
  input  xbr_cfg_t   cfg_i,
  input  logic [1:0] func_i,
  input  logic [7:0] rx_byte_i,
  output xbr_state_t state_o,
  output xbr_res_t   res_o
);

  function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] x;
    x = c ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      x = x[15] ? ((x << 1) ^ CRC_POLY) : (x << 1);
    end
    return x;
  endfunction

  xbr_state_t s;
  xbr_res_t   r;
  logic       active;
  logic       fail_req;
  logic [2:0] fail_code;
  logic [3:0] cnt;
  logic       abort_now;
  logic [1:0] fail_verd;
  logic [10:0] len;
  logic [15:0] limit;
  logic [15:0] sil_inc;
  logic        check_good;

  always_comb begin
    s          = state_i;
    r          = '0;
    r.kind     = RES_NONE;
    fail_req   = 1'b0;
    fail_code  = ERR_NONE;
    cnt        = 4'd0;
    abort_now  = 1'b0;
    fail_verd  = VERD_NONE;
    active     = (state_i.phase == PH_HEADER) || (state_i.phase == PH_NUM) ||
                 (state_i.phase == PH_CMP) || (state_i.phase == PH_BODY);
    len        = state_i.long_frame ? LONG_LEN : SHORT_LEN;
    limit      = (state_i.phase == PH_HEADER && !state_i.byte_seen) ?
                 cfg_i.long_to : cfg_i.short_to;
    sil_inc    = (state_i.silence == SIL_MAX) ? state_i.silence : state_i.silence + 16'd1;
    check_good = state_i.crc_mode ?
                 (state_i.check_hi == state_i.crc[15:8] && rx_byte_i == state_i.crc[7:0]) :
                 (rx_byte_i == state_i.sum);

    priority case (func_i)
      FUNC_BYTE: begin
        if (active) begin
          s.silence = '0;
          unique case (state_i.phase)
            PH_HEADER: begin
              s.byte_seen = 1'b1;
              if (rx_byte_i == C_SOH || rx_byte_i == C_STX) begin
                s.long_frame = (rx_byte_i == C_STX);
                s.crc        = '0;
                s.sum        = '0;
                s.check_hi   = '0;
                s.byte_index = '0;
                s.phase      = PH_NUM;
              end else if (rx_byte_i == C_EOT) begin
                s.err_cnt     = '0;
                s.phase       = PH_DONE;
                r.kind        = RES_ONE;
                r.reply_valid = 1'b1;
                r.reply_byte  = C_ACK;
              end else begin
                fail_req  = 1'b1;
                fail_code = ERR_HEADER;
              end
            end
            PH_NUM: begin
              s.received_block = rx_byte_i;
              s.phase          = PH_CMP;
            end
            PH_CMP: begin
              if ((state_i.received_block ^ rx_byte_i) != CMP_OK) begin
                fail_req  = 1'b1;
                fail_code = ERR_CMP;
              end else begin
                s.phase      = PH_BODY;
                s.byte_index = '0;
              end
            end
            default: begin
              if (state_i.byte_index < len) begin
                s.sum        = state_i.sum + rx_byte_i;
                s.crc        = crc_byte(state_i.crc, rx_byte_i);
                s.byte_index = state_i.byte_index + 11'd1;
                r.kind       = RES_ONE;
                r.data_valid = 1'b1;
                r.data_byte  = rx_byte_i;
              end else if (state_i.byte_index == len && state_i.crc_mode) begin
                s.check_hi   = rx_byte_i;
                s.byte_index = state_i.byte_index + 11'd1;
              end else if (state_i.received_block == state_i.expected_block - 8'd1) begin
                s.err_cnt     = '0;
                r.kind        = RES_ONE;
                r.reply_valid = 1'b1;
                r.reply_byte  = C_ACK;
                r.verdict     = VERD_DISCARD;
                s.phase       = PH_HEADER;
                s.byte_index  = '0;
                s.silence     = '0;
              end else if (state_i.received_block != state_i.expected_block) begin
                fail_req  = 1'b1;
                fail_code = ERR_BLOCKNUM;
              end else if (!check_good) begin
                fail_req  = 1'b1;
                fail_code = ERR_CHECK;
              end else begin
                s.expected_block = state_i.expected_block + 8'd1;
                s.committed      = state_i.committed + {21'd0, len};
                s.err_cnt        = '0;
                r.kind           = RES_ONE;
                r.reply_valid    = 1'b1;
                r.reply_byte     = C_ACK;
                r.verdict        = VERD_COMMIT;
                s.phase          = PH_HEADER;
                s.byte_index     = '0;
                s.silence        = '0;
              end
            end
          endcase
        end
      end
      FUNC_TICK: begin
        if (active) begin
          s.silence = sil_inc;
          if (sil_inc >= limit) begin
            s.silence = '0;
            fail_req  = 1'b1;
            fail_code = ERR_TIMEOUT;
          end
        end
      end
      FUNC_START: begin
        if (!active) begin
          s.byte_index     = '0;
          s.long_frame     = 1'b0;
          s.expected_block = 8'd1;
          s.received_block = '0;
          s.crc            = '0;
          s.sum            = '0;
          s.check_hi       = '0;
          s.crc_mode       = 1'b1;
          s.err_cnt        = '0;
          s.silence        = '0;
          s.byte_seen      = 1'b0;
          s.committed      = '0;
          s.phase          = PH_HEADER;
          r.kind           = RES_ONE;
          r.reply_valid    = 1'b1;
          r.reply_byte     = C_ASKCRC;
        end
      end
      default: begin
      end
    endcase

    if (fail_req) begin
      fail_verd = (s.phase == PH_BODY && s.byte_index != '0) ? VERD_DISCARD : VERD_NONE;
      cnt       = s.err_cnt + 4'd1;
      if (cnt == cfg_i.max_err) begin
        if (s.crc_mode && !s.byte_seen) begin
          s.crc_mode = 1'b0;
          cnt        = 4'd1;
          abort_now  = (cnt == cfg_i.max_err);
        end else begin
          abort_now = 1'b1;
        end
      end
      s.err_cnt    = cnt;
      s.byte_index = '0;
      s.silence    = '0;
      r.verdict    = fail_verd;
      r.err        = fail_code;
      if (abort_now) begin
        s.phase = PH_ABORT;
        r.kind  = RES_ABORT;
      end else begin
        s.phase       = PH_HEADER;
        r.kind        = RES_ONE;
        r.reply_valid = 1'b1;
        r.reply_byte  = (s.crc_mode && !s.byte_seen) ? C_ASKCRC : C_NAK;
      end
    end

    unique case (s.phase)
      PH_IDLE:  r.status = ST_IDLE;
      PH_DONE:  r.status = ST_FINISHED;
      PH_ABORT: r.status = ST_ABORTED;
      default:  r.status = ST_RECEIVE;
    endcase
    r.crc_in_use = s.crc_mode;
    r.total      = s.committed;
  end

  assign state_o = s;
  assign res_o   = r;

endmodule

### hdl/xbr_out.sv
// Result register and sequencer: one beat per result, ten beats for an abort.
// Depends on xbr_pkg.
module xbr_out import xbr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        load_i,
  input  xbr_res_t    res_i,
  output logic        free_o,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,   // reply_byte, data_byte, block_verdict, error_code,
                                   // status, crc_in_use, total_bytes
  output logic [1:0]  out_tuser,   // reply_valid, data_valid
  output logic        out_tlast
);

  localparam logic [3:0] LAST_BEAT = 4'(ABORT_BEATS - 1);
  localparam logic [3:0] CAN_BEATS = 4'(ABORT_CANS);

  logic       vld_r, vld_nxt;
  logic [3:0] beat_r, beat_nxt;
  xbr_res_t   res_r;
  logic       is_abort;
  logic       last_beat;
  logic       xfer;
  logic       rv;
  logic [7:0] rb;
  logic [1:0] verd;
  logic [2:0] err;

  assign is_abort  = (res_r.kind == RES_ABORT);
  assign last_beat = !is_abort || (beat_r == LAST_BEAT);
  assign xfer      = vld_r && out_tready;
  assign free_o    = !vld_r || (out_tready && last_beat);

  always_comb begin
    vld_nxt  = vld_r;
    beat_nxt = beat_r;
    if (xfer && !last_beat) begin
      beat_nxt = beat_r + 4'd1;
    end else if (free_o) begin
      vld_nxt  = load_i;
      beat_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= 1'b0;
      beat_r <= '0;
    end else begin
      vld_r  <= vld_nxt;
      beat_r <= beat_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (free_o && load_i) begin
      res_r <= res_i;
    end
  end

  always_comb begin
    if (is_abort) begin
      rv   = 1'b1;
      rb   = (beat_r < CAN_BEATS) ? C_CAN : C_BS;
      verd = (beat_r == '0) ? res_r.verdict : VERD_NONE;
      err  = (beat_r == '0) ? res_r.err : ERR_NONE;
    end else begin
      rv   = res_r.reply_valid;
      rb   = res_r.reply_byte;
      verd = res_r.verdict;
      err  = res_r.err;
    end
  end

  assign out_tvalid = vld_r;
  assign out_tlast  = last_beat;
  assign out_tuser  = {res_r.data_valid && !is_abort, rv};
  assign out_tdata  = {res_r.total, res_r.crc_in_use, res_r.status, err, verd,
                       is_abort ? 8'h00 : res_r.data_byte, rb};

endmodule

### hdl/xmodem_block_receiver_core.sv
// Top level of the XMODEM block receiver: input register, receiver state,
// configuration registers. Depends on xbr_pkg, xbr_step and xbr_out.
//
//  channel  direction  transfer on            payload
//  in_      slave      in_tvalid & in_tready  tuser func, tdata rx_byte
//  out_     master     out_tvalid & out_tready tuser flags, tdata result, tlast
//  cfg_     write      cfg_wr_en              cfg_index, cfg_wdata
//
// One item per cycle unless the output stalls: an item waits in the input register,
// and the step logic (CRC-16 byte update, silence compare) updates state in one pass.
// Results leave from the output register; an abort holds it for ten beats.
// Reset restores the state, valid flags and config registers; no clearing pass.
// A stalled output holds the input register only for items that produce results.
module xmodem_block_receiver_core import xbr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // rx_byte
  input  logic [1:0]  in_tuser,    // func
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,   // reply_byte, data_byte, block_verdict, error_code,
                                   // status, crc_in_use, total_bytes
  output logic [1:0]  out_tuser,   // reply_valid, data_valid
  output logic        out_tlast,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  logic       in_vld_r;
  logic [1:0] func_r;
  logic [7:0] byte_r;
  xbr_state_t state_r, state_nxt;
  xbr_cfg_t   cfg_r;
  xbr_res_t   res;
  logic       out_free;
  logic       adv;

  xbr_step u_step (
    .state_i   (state_r),
    .cfg_i     (cfg_r),
    .func_i    (func_r),
    .rx_byte_i (byte_r),
    .state_o   (state_nxt),
    .res_o     (res)
  );

  assign adv       = in_vld_r && ((res.kind == RES_NONE) || out_free);
  assign in_tready = !in_vld_r || adv;

  xbr_out u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load_i     (adv && (res.kind != RES_NONE)),
    .res_i      (res),
    .free_o     (out_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      func_r <= in_tuser;
      byte_r <= in_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= STATE_RST;
    end else if (adv) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_LONG_TO:  cfg_r.long_to  <= cfg_wdata;
        CFG_SHORT_TO: cfg_r.short_to <= cfg_wdata;
        CFG_MAX_ERR:  cfg_r.max_err  <= cfg_wdata[3:0];
        default: begin
        end
      endcase
    end
  end

  a_start_enters_header: assert property (@(posedge clk) disable iff (!rst_n)
    adv && func_r == FUNC_START && (state_r.phase == PH_IDLE ||
      state_r.phase == PH_DONE || state_r.phase == PH_ABORT)
    |=> state_r.phase == PH_HEADER && out_tvalid)
    else $error("start did not enter header phase");

  a_index_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.byte_index <= LONG_LEN + 11'd1)
    else $error("byte index beyond frame");

  a_state_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(state_r))
    else $error("state changed without an item");

  a_item_held: assert property (@(posedge clk) disable iff (!rst_n)
    in_vld_r && !adv |=> in_vld_r && $stable(func_r) && $stable(byte_r))
    else $error("held item lost");

endmodule

### tb/xbr_checker.sv
// Scoreboard for the XMODEM block receiver: follows the receiver state for each
// input transfer, queues the results it must produce and compares the output stream.
// Depends on xbr_pkg for protocol codes, register indexes and the phase enum.
module xbr_checker import xbr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,
  input  logic [1:0]  in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [55:0] out_tdata,
  input  logic [1:0]  out_tuser,
  input  logic        out_tlast,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  output int          fails,
  output int          pending,
  output int          results_seen,
  output logic        pred_crc,
  output logic [7:0]  pred_block,
  output logic [1:0]  pred_status
);

  typedef struct packed {
    logic        rv;
    logic [7:0]  rb;
    logic        dv;
    logic [7:0]  db;
    logic [1:0]  verdict;
    logic [2:0]  err;
    logic [1:0]  status;
    logic        crc;
    logic [31:0] total;
    logic        fin;
  } beat_t;

  beat_t reply_q[$];
  beat_t item_beats[$];

  logic [15:0] lim_long, lim_short;
  logic [3:0]  lim_err;

  phase_t      ph;
  logic [10:0] idx;
  logic        lng;
  logic [7:0]  exp_blk, rcv_blk;
  logic [15:0] crc;
  logic [7:0]  csum, chk_hi;
  logic        crc_on;
  logic [3:0]  errs;
  logic [15:0] quiet;
  logic        seen;
  logic [31:0] committed;

  function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    r = c ^ {b, 8'h00};
    for (int k = 0; k < 8; k++)
      r = r[15] ? ((r << 1) ^ CRC_POLY) : (r << 1);
    return r;
  endfunction

  function void push_beat(input logic rv, input logic [7:0] rb, input logic dv,
                          input logic [7:0] db, input logic [1:0] verdict,
                          input logic [2:0] err);
    beat_t t;
    t = '0;
    t.rv = rv;
    t.rb = rb;
    t.dv = dv;
    t.db = db;
    t.verdict = verdict;
    t.err = err;
    item_beats.push_back(t);
  endfunction

  function void rewind();
    ph = PH_HEADER;
    idx = '0;
    quiet = '0;
  endfunction

  function void restart_transfer();
    idx = '0;
    lng = 1'b0;
    exp_blk = 8'd1;
    rcv_blk = '0;
    crc = '0;
    csum = '0;
    chk_hi = '0;
    crc_on = 1'b1;
    errs = '0;
    quiet = '0;
    seen = 1'b0;
    committed = '0;
  endfunction

  function void raise_error(input logic [2:0] code);
    logic [1:0] verdict;
    logic [3:0] cnt;
    logic       quit;
    verdict = (ph == PH_BODY && idx != 0) ? VERD_DISCARD : VERD_NONE;
    cnt = errs + 4'd1;
    quit = 1'b0;
    if (cnt == lim_err) begin
      if (crc_on && !seen) begin
        crc_on = 1'b0;
        cnt = 4'd1;
        quit = (cnt == lim_err);
      end else begin
        quit = 1'b1;
      end
    end
    errs = cnt;
    if (quit) begin
      ph = PH_ABORT;
      idx = '0;
      quiet = '0;
      for (int i = 0; i < ABORT_BEATS; i++)
        push_beat(1'b1, (i < ABORT_CANS) ? C_CAN : C_BS, 1'b0, 8'h00,
                  (i == 0) ? verdict : VERD_NONE, (i == 0) ? code : ERR_NONE);
    end else begin
      push_beat(1'b1, (crc_on && !seen) ? C_ASKCRC : C_NAK, 1'b0, 8'h00, verdict, code);
      rewind();
    end
  endfunction

  function void close_frame(input logic [7:0] chk);
    logic [10:0] len;
    logic        good;
    len = lng ? LONG_LEN : SHORT_LEN;
    if (rcv_blk == 8'(exp_blk - 8'd1)) begin
      errs = '0;
      push_beat(1'b1, C_ACK, 1'b0, 8'h00, VERD_DISCARD, ERR_NONE);
      rewind();
    end else if (rcv_blk != exp_blk) begin
      raise_error(ERR_BLOCKNUM);
    end else begin
      if (crc_on)
        good = (chk_hi == crc[15:8]) && (chk == crc[7:0]);
      else
        good = (chk == csum);
      if (!good) begin
        raise_error(ERR_CHECK);
      end else begin
        exp_blk = exp_blk + 8'd1;
        committed = committed + 32'(len);
        errs = '0;
        push_beat(1'b1, C_ACK, 1'b0, 8'h00, VERD_COMMIT, ERR_NONE);
        rewind();
      end
    end
  endfunction

  function void take_line_byte(input logic [7:0] b);
    logic [10:0] len;
    len = lng ? LONG_LEN : SHORT_LEN;
    quiet = '0;
    case (ph)
      PH_HEADER: begin
        seen = 1'b1;
        if (b == C_SOH || b == C_STX) begin
          lng = (b == C_STX);
          crc = '0;
          csum = '0;
          chk_hi = '0;
          idx = '0;
          ph = PH_NUM;
        end else if (b == C_EOT) begin
          errs = '0;
          ph = PH_DONE;
          push_beat(1'b1, C_ACK, 1'b0, 8'h00, VERD_NONE, ERR_NONE);
        end else begin
          raise_error(ERR_HEADER);
        end
      end
      PH_NUM: begin
        rcv_blk = b;
        ph = PH_CMP;
      end
      PH_CMP: begin
        if ((rcv_blk ^ b) != CMP_OK) begin
          raise_error(ERR_CMP);
        end else begin
          ph = PH_BODY;
          idx = '0;
        end
      end
      PH_BODY: begin
        if (idx < len) begin
          csum = csum + b;
          crc = crc_byte(crc, b);
          idx = idx + 11'd1;
          push_beat(1'b0, 8'h00, 1'b1, b, VERD_NONE, ERR_NONE);
        end else if (idx == len && crc_on) begin
          chk_hi = b;
          idx = idx + 11'd1;
        end else begin
          close_frame(b);
        end
      end
      default: ;
    endcase
  endfunction

  function void predict(input logic [1:0] f, input logic [7:0] b);
    logic        active;
    logic [15:0] lim;
    logic [1:0]  st;
    beat_t       t;
    item_beats.delete();
    active = (ph >= PH_HEADER) && (ph <= PH_BODY);
    case (f)
      FUNC_BYTE: begin
        if (active)
          take_line_byte(b);
      end
      FUNC_TICK: begin
        if (active) begin
          lim = (ph == PH_HEADER && !seen) ? lim_long : lim_short;
          if (quiet != SIL_MAX)
            quiet = quiet + 16'd1;
          if (quiet >= lim) begin
            quiet = '0;
            raise_error(ERR_TIMEOUT);
          end
        end
      end
      FUNC_START: begin
        if (!active) begin
          restart_transfer();
          ph = PH_HEADER;
          push_beat(1'b1, C_ASKCRC, 1'b0, 8'h00, VERD_NONE, ERR_NONE);
        end
      end
      default: ;
    endcase
    case (ph)
      PH_IDLE:  st = ST_IDLE;
      PH_DONE:  st = ST_FINISHED;
      PH_ABORT: st = ST_ABORTED;
      default:  st = ST_RECEIVE;
    endcase
    for (int k = 0; k < item_beats.size(); k++) begin
      t = item_beats[k];
      t.status = st;
      t.crc = crc_on;
      t.total = committed;
      t.fin = (k == item_beats.size() - 1);
      reply_q.push_back(t);
    end
  endfunction

  task report(input string what, input logic [31:0] got, input logic [31:0] want);
    if (fails < 40)
      $display("MISMATCH at result %0d: %s got 0x%0h expected 0x%0h",
               results_seen, what, got, want);
    fails++;
  endtask

  always @(posedge clk) begin
    beat_t got, want;
    if (!rst_n) begin
      lim_long = LONG_TO_RST;
      lim_short = SHORT_TO_RST;
      lim_err = MAX_ERR_RST;
      restart_transfer();
      ph = PH_IDLE;
      reply_q.delete();
      fails = 0;
      results_seen = 0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_LONG_TO:  lim_long = cfg_wdata;
          CFG_SHORT_TO: lim_short = cfg_wdata;
          CFG_MAX_ERR:  lim_err = cfg_wdata[3:0];
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        results_seen++;
        got.rv = out_tuser[0];
        got.dv = out_tuser[1];
        got.rb = out_tdata[7:0];
        got.db = out_tdata[15:8];
        got.verdict = out_tdata[17:16];
        got.err = out_tdata[20:18];
        got.status = out_tdata[22:21];
        got.crc = out_tdata[23];
        got.total = out_tdata[55:24];
        got.fin = out_tlast;
        if (reply_q.size() == 0) begin
          report("unexpected result, reply_byte", 32'(got.rb), 32'd0);
        end else begin
          want = reply_q.pop_front();
          if (got.rv !== want.rv) report("reply_valid", 32'(got.rv), 32'(want.rv));
          if (got.rb !== want.rb) report("reply_byte", 32'(got.rb), 32'(want.rb));
          if (got.dv !== want.dv) report("data_valid", 32'(got.dv), 32'(want.dv));
          if (got.db !== want.db) report("data_byte", 32'(got.db), 32'(want.db));
          if (got.verdict !== want.verdict)
            report("block_verdict", 32'(got.verdict), 32'(want.verdict));
          if (got.err !== want.err) report("error_code", 32'(got.err), 32'(want.err));
          if (got.status !== want.status)
            report("status", 32'(got.status), 32'(want.status));
          if (got.crc !== want.crc) report("crc_in_use", 32'(got.crc), 32'(want.crc));
          if (got.total !== want.total) report("total_bytes", got.total, want.total);
          if (got.fin !== want.fin) report("last", 32'(got.fin), 32'(want.fin));
        end
      end
      if (in_tvalid && in_tready)
        predict(in_tuser, in_tdata);
    end
    pending = reply_q.size();
    pred_crc = crc_on;
    pred_block = exp_blk;
    case (ph)
      PH_IDLE:  pred_status = ST_IDLE;
      PH_DONE:  pred_status = ST_FINISHED;
      PH_ABORT: pred_status = ST_ABORTED;
      default:  pred_status = ST_RECEIVE;
    endcase
  end

endmodule

### tb/testbench.sv
// Top of the XMODEM receiver testbench: clock, reset, line and tick stimulus,
// register writes, output back-pressure, stall watchdog and the final verdict.
// Depends on xbr_pkg, xbr_checker and xmodem_block_receiver_core.
module testbench;
  import xbr_pkg::*;

  localparam logic [1:0] FUNC_BAD = 2'd3;
  localparam int HOLD_CYCLES = 300;
  localparam int STALL_LIMIT = 4000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;
  logic [1:0]  in_tuser = 2'd0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [55:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;
  logic        cfg_wr_en = 1'b0;
  logic [1:0]  cfg_index = 2'd0;
  logic [15:0] cfg_wdata = 16'd0;

  int          fails, pending, results_seen;
  logic        pred_crc;
  logic [7:0]  pred_block;
  logic [1:0]  pred_status;

  bit          calm = 1'b0;
  bit          hold_go = 1'b0;
  int          items_sent = 0;
  int          frames_sent = 0;
  int          quiet_cycles = 0;

  xmodem_block_receiver_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  xbr_checker u_chk (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .fails(fails), .pending(pending), .results_seen(results_seen),
    .pred_crc(pred_crc), .pred_block(pred_block), .pred_status(pred_status)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Watchdog: no transfer for %0d cycles, %0d results outstanding",
                 STALL_LIMIT, pending);
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin
    bit held;
    held = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_go && !held) begin
        held = 1'b1;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      out_tready <= calm || ($urandom_range(99) >= 11);
    end
  end

  task send_item(input logic [1:0] f, input logic [7:0] b);
    while (!calm && $urandom_range(99) < 11) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= f;
    in_tdata <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  task settle();
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task set_regs(input logic [15:0] lt, input logic [15:0] st, input logic [3:0] me);
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_LONG_TO;
    cfg_wdata <= lt;
    @(negedge clk);
    cfg_index <= CFG_SHORT_TO;
    cfg_wdata <= st;
    @(negedge clk);
    cfg_index <= CFG_MAX_ERR;
    cfg_wdata <= {12'd0, me};
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // cut >= 0 stops after that many payload bytes; a bad complement stops after it
  task send_frame(input bit is_long, input logic [7:0] blk, input logic [7:0] cmp,
                  input bit bad_check, input int cut);
    logic [15:0] c;
    logic [7:0]  s, b, hi, lo, mask;
    int          len;
    bit          use_crc;
    use_crc = pred_crc;
    c = '0;
    s = '0;
    len = is_long ? 1024 : 128;
    frames_sent++;
    send_item(FUNC_BYTE, is_long ? C_STX : C_SOH);
    send_item(FUNC_BYTE, blk);
    send_item(FUNC_BYTE, cmp);
    if (cmp != ~blk) return;
    for (int i = 0; i < len; i++) begin
      if (cut >= 0 && i == cut) return;
      b = 8'($urandom);
      c = u_chk.crc_byte(c, b);
      s = s + b;
      send_item(FUNC_BYTE, b);
    end
    mask = bad_check ? 8'(1 << $urandom_range(7)) : 8'h00;
    if (use_crc) begin
      hi = c[15:8];
      lo = c[7:0];
      if ($urandom_range(1)) hi = hi ^ mask;
      else lo = lo ^ mask;
      send_item(FUNC_BYTE, hi);
      send_item(FUNC_BYTE, lo);
    end else begin
      send_item(FUNC_BYTE, s ^ mask);
    end
  endtask

  initial begin
    int n;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // idle-state items, start, ignored start, header and complement errors, EOT
    send_item(FUNC_BYTE, 8'hFF);
    send_item(FUNC_TICK, 8'h00);
    send_item(FUNC_BAD, 8'hAA);
    send_item(FUNC_START, 8'h00);
    send_item(FUNC_START, 8'hFF);
    send_item(FUNC_BAD, 8'h55);
    send_item(FUNC_BYTE, 8'h00);
    send_item(FUNC_BYTE, C_SOH);
    send_item(FUNC_BYTE, 8'h05);
    send_item(FUNC_BYTE, 8'h05);
    send_item(FUNC_BYTE, C_EOT);
    send_item(FUNC_BYTE, C_SOH);
    send_item(FUNC_TICK, 8'h00);

    // timeouts: fallback to checksum, then abort
    settle();
    set_regs(16'd1, 16'd1, 4'd2);
    send_item(FUNC_START, 8'h00);
    repeat (4) send_item(FUNC_TICK, 8'h00);

    // a single error limit aborts straight after the fallback
    settle();
    set_regs(16'd1, 16'd1, 4'd1);
    send_item(FUNC_START, 8'h00);
    send_item(FUNC_TICK, 8'h00);

    // widest limits; hold the output off while a short frame streams in
    settle();
    set_regs(16'hFFFF, 16'hFFFF, 4'd15);
    send_item(FUNC_START, 8'h00);
    hold_go = 1'b1;
    calm = 1'b1;
    send_frame(1'b0, pred_block, ~pred_block, 1'b0, -1);
    calm = 1'b0;

    // checksum mode through timeouts, then a long frame cut short aborts
    settle();
    set_regs(16'd2, 16'd1, 4'd2);
    send_item(FUNC_START, 8'h00);
    n = 0;
    while (pred_status == ST_RECEIVE && pred_crc && n < 40) begin
      send_item(FUNC_TICK, 8'($urandom));
      n++;
    end
    send_frame(1'b1, pred_block, ~pred_block, 1'b0, 4);
    send_item(FUNC_TICK, 8'h00);

    // zero limits: every tick times out until the error limit aborts
    settle();
    set_regs(16'd0, 16'd0, 4'd3);
    send_item(FUNC_START, 8'h00);
    n = 0;
    while (pred_status == ST_RECEIVE && n < 40) begin
      send_item(FUNC_TICK, 8'h00);
      n++;
    end

    settle();
    repeat (10) @(negedge clk);
    $display("Run covered %0d input transfers, %0d checked results, %0d frames offered",
             items_sent, results_seen, frames_sent);
    $display("Modes: CRC commit under output hold-off, checksum fallback, timeouts, aborts");
    if (fails == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

### filelist.f
hdl/xbr_pkg.sv
hdl/xbr_step.sv
hdl/xbr_out.sv
hdl/xmodem_block_receiver_core.sv
tb/xbr_checker.sv
tb/testbench.sv
